@@ hdl/life_like_automaton_row_step_assert.svh @@
// Assertion macros for the life-like automaton row step block.
`ifndef LIFE_LIKE_AUTOMATON_ROW_STEP_ASSERT_SVH
`define LIFE_LIKE_AUTOMATON_ROW_STEP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LLA_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lla assertion failed");

// next-cycle implication, checked out of reset
`define LLA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lla assertion failed");

`endif

@@ hdl/lla_pkg.sv @@
// Shared types and constants for the life-like automaton row step block.
`timescale 1ns / 1ps
package lla_pkg;

  localparam int unsigned ROW_W   = 64;
  localparam int unsigned AW_W    = 7;
  localparam int unsigned RULE_W  = 9;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned QDEPTH  = 3;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 2;

  localparam logic [AW_W-1:0]   ACTIVE_WIDTH_RST = 7'd64;
  localparam logic [RULE_W-1:0] BIRTH_MASK_RST   = 9'd8;
  localparam logic [RULE_W-1:0] SURVIVE_MASK_RST = 9'd12;

  typedef enum logic [1:0] {
    REG_ACTIVE_WIDTH = 2'd0,
    REG_BIRTH_MASK   = 2'd1,
    REG_SURVIVE_MASK = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic u;
    logic m;
    logic r;
  } nbr_t;

  typedef struct packed {
    logic [RULE_W-1:0] birth;
    logic [RULE_W-1:0] survive;
  } rule_t;

  typedef struct packed {
    logic             held;
    logic             last;
    logic             acc;
  } step_ctl_t;

  typedef struct packed {
    logic [ROW_W-1:0] cells;
    logic             last;
  } res_t;

  function automatic logic [QPTR_W-1:0] qptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    n = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    return n;
  endfunction

endpackage

@@ hdl/lla_cell.sv @@
// One grid column: holds two row bits and computes the column's next state.
`timescale 1ns / 1ps
module lla_cell import lla_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  step_ctl_t ctl_i,
  input  logic      row_i,
  input  nbr_t      left_i,
  input  nbr_t      right_i,
  input  rule_t     rule_i,
  output nbr_t      own_o,
  output logic      next_o,
  output logic      flush_o
);

  logic             u_q, u_d;
  logic             m_q, m_d;
  logic [CNT_W-1:0] n_norm;
  logic [CNT_W-1:0] n_flush;
  logic [CNT_W-1:0] n_above;

  assign own_o.u = u_q & en_i;
  assign own_o.m = m_q & en_i;
  assign own_o.r = row_i & en_i;

  assign n_norm = CNT_W'(left_i.u) + CNT_W'(left_i.m) + CNT_W'(left_i.r)
                + CNT_W'(right_i.u) + CNT_W'(right_i.m) + CNT_W'(right_i.r)
                + CNT_W'(own_o.u) + CNT_W'(own_o.r);

  assign n_above = CNT_W'(left_i.m) + CNT_W'(own_o.m) + CNT_W'(right_i.m);
  assign n_flush = (ctl_i.held ? n_above : '0) + CNT_W'(left_i.r) + CNT_W'(right_i.r);

  assign next_o  = en_i & (own_o.m ? rule_i.survive[n_norm] : rule_i.birth[n_norm]);
  assign flush_o = en_i & (own_o.r ? rule_i.survive[n_flush] : rule_i.birth[n_flush]);

  always_comb begin
    u_d = u_q;
    m_d = m_q;
    if (ctl_i.acc) begin
      if (ctl_i.last) begin
        u_d = 1'b0;
        m_d = 1'b0;
      end else begin
        u_d = ctl_i.held ? m_q : 1'b0;
        m_d = own_o.r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q <= 1'b0;
      m_q <= 1'b0;
    end else begin
      u_q <= u_d;
      m_q <= m_d;
    end
  end

endmodule

@@ hdl/lla_outq.sv @@
// Three-entry result queue taking up to two results per cycle.
`timescale 1ns / 1ps
module lla_outq import lla_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        wr_cnt_i,
  input  res_t              wr0_i,
  input  res_t              wr1_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic              full2_o,
  output res_t              rd_o
);

  res_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] head_q, head_d;
  logic [QPTR_W-1:0] tail_q, tail_d;
  logic [QPTR_W-1:0] tail_nx;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_pop;

  assign valid_o = (cnt_q != '0);
  assign full2_o = (cnt_q > QCNT_W'(1));
  assign rd_o    = mem_q[head_q];
  assign do_pop  = pop_i & valid_o;
  assign tail_nx = qptr_inc(tail_q);

  always_comb begin
    head_d = do_pop ? qptr_inc(head_q) : head_q;
    unique case (wr_cnt_i)
      2'd0:    tail_d = tail_q;
      2'd1:    tail_d = tail_nx;
      default: tail_d = qptr_inc(tail_nx);
    endcase
    cnt_d = cnt_q + QCNT_W'(wr_cnt_i) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) begin
      mem_q[tail_q] <= wr0_i;
    end
    if (wr_cnt_i == 2'd2) begin
      mem_q[tail_nx] <= wr1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

@@ hdl/life_like_automaton_row_step.sv @@
// Life-like automaton row step: one input row per unstalled cycle in, next-generation
// rows out. Rows of the current generation enter top row first, one request per clock
// while in_stall_o is low. A row of GRID_WIDTH column cells holds the two most recent
// rows and exchanges bits with its neighbors; the results of each accepted row (none
// for a grid's first row, one per later row, two for the bottom row if not the first)
// land in a three-entry result queue and leave one per cycle while not stalled.
// Input is stalled while the queue holds two or more results. Columns at and above
// the active width (saturated to GRID_WIDTH) are dead and read back as zero. Rule and
// width registers sit on an APB port at byte offsets 0, 4, 8.
`timescale 1ns / 1ps
`include "life_like_automaton_row_step_assert.svh"
module life_like_automaton_row_step import lla_pkg::*; #(
  parameter int unsigned GRID_WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ROW_W-1:0]  row_cells_i,
  input  logic              last_row_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ROW_W-1:0]  next_row_cells_o,
  output logic              last_of_grid_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [AW_W-1:0]   active_width_q;
  logic [RULE_W-1:0] birth_mask_q;
  logic [RULE_W-1:0] survive_mask_q;
  logic              held_q, held_d;
  logic              acc_w;
  logic              cfg_wr;
  reg_idx_e          reg_idx;
  logic [AW_W-1:0]   eff_w;
  rule_t             rule_w;
  step_ctl_t         ctl_w;
  nbr_t              own_w [GRID_WIDTH];
  logic [ROW_W-1:0]  next_w;
  logic [ROW_W-1:0]  flush_w;
  logic [1:0]        wr_cnt;
  res_t              wr0, wr1, rd_w;
  logic              q_full2;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    unique case (reg_idx)
      REG_ACTIVE_WIDTH: prdata = DATA_W'(active_width_q);
      REG_BIRTH_MASK:   prdata = DATA_W'(birth_mask_q);
      REG_SURVIVE_MASK: prdata = DATA_W'(survive_mask_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_width_q <= ACTIVE_WIDTH_RST;
      birth_mask_q   <= BIRTH_MASK_RST;
      survive_mask_q <= SURVIVE_MASK_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ACTIVE_WIDTH: active_width_q <= pwdata[AW_W-1:0];
        REG_BIRTH_MASK:   birth_mask_q   <= pwdata[RULE_W-1:0];
        REG_SURVIVE_MASK: survive_mask_q <= pwdata[RULE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign eff_w = (active_width_q > AW_W'(GRID_WIDTH)) ? AW_W'(GRID_WIDTH) : active_width_q;
  assign rule_w.birth   = birth_mask_q;
  assign rule_w.survive = survive_mask_q;

  assign acc_w      = in_valid_i & ~in_stall_o;
  assign ctl_w.acc  = acc_w;
  assign ctl_w.last = last_row_i;
  assign ctl_w.held = held_q;

  assign held_d = acc_w ? ~last_row_i : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
    end else begin
      held_q <= held_d;
    end
  end

  for (genvar j = 0; j < GRID_WIDTH; j++) begin : g_col
    nbr_t left_w;
    nbr_t right_w;
    if (j == 0) begin : g_ledge
      assign left_w = '0;
    end else begin : g_lnbr
      assign left_w = own_w[j-1];
    end
    if (j == GRID_WIDTH - 1) begin : g_redge
      assign right_w = '0;
    end else begin : g_rnbr
      assign right_w = own_w[j+1];
    end
    lla_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (AW_W'(j) < eff_w),
      .ctl_i   (ctl_w),
      .row_i   (row_cells_i[j]),
      .left_i  (left_w),
      .right_i (right_w),
      .rule_i  (rule_w),
      .own_o   (own_w[j]),
      .next_o  (next_w[j]),
      .flush_o (flush_w[j])
    );
  end

  if (GRID_WIDTH < ROW_W) begin : g_pad
    assign next_w[ROW_W-1:GRID_WIDTH]  = '0;
    assign flush_w[ROW_W-1:GRID_WIDTH] = '0;
  end

  always_comb begin
    wr_cnt     = acc_w ? (2'(held_q) + 2'(last_row_i)) : 2'd0;
    wr0.cells  = held_q ? next_w : flush_w;
    wr0.last   = ~held_q;
    wr1.cells  = flush_w;
    wr1.last   = 1'b1;
  end

  lla_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_cnt_i (wr_cnt),
    .wr0_i    (wr0),
    .wr1_i    (wr1),
    .pop_i    (~out_stall_i),
    .valid_o  (out_valid_o),
    .full2_o  (q_full2),
    .rd_o     (rd_w)
  );

  assign in_stall_o       = q_full2;
  assign next_row_cells_o = rd_w.cells;
  assign last_of_grid_o   = rd_w.last;

  `LLA_ASSERT_NEXT(a_last_clears_held, clk_i, rst_ni, acc_w && last_row_i, !held_q)
  `LLA_ASSERT_NEXT(a_row_sets_held, clk_i, rst_ni, acc_w && !last_row_i, held_q)
  `LLA_ASSERT_NEXT(a_last_gives_result, clk_i, rst_ni, acc_w && last_row_i, out_valid_o)
  `LLA_ASSERT_NOW(a_no_accept_when_full, clk_i, rst_ni, q_full2, !acc_w)

endmodule
